/* hdl/rac_pkg.sv */
// region access checker package: command codes, field width and the control
// word that travels along the cell chain
// no dependencies
`timescale 1ns / 1ps

package rac_pkg;

   // width of the address-like fields on the request ports
   localparam int FIELD_BITS = 32;
   // width of the slot field on the request ports
   localparam int SLOT_BITS = 4;

   // command codes
   typedef enum logic [1:0] {
      CMD_CHECK = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_CLEAR = 2'd2
   } rac_cmd_type;

   // control word handed from cell to cell with each transaction
   typedef struct packed {
      logic                 valid;
      rac_cmd_type          cmd;
      logic [SLOT_BITS-1:0] slot;
      logic                 rd;         // write: region readable
      logic                 wr;         // write: region writable
      logic                 want_write; // check: access needs write permission
      logic                 ok;         // check: access usable; write: region usable
      logic                 hit;        // check: some cell so far grants it
   } rac_ctl_type;

endpackage

/* hdl/rac_cell.sv */
// region access checker cell: holds one region slot and checks the passing
// transaction against it before handing it to the next cell
// depends on rac_pkg
`timescale 1ns / 1ps

module rac_cell #(
   parameter int INDEX     = 0,
   parameter int ADDR_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rac_pkg::rac_ctl_type     up_ctl,
   input  logic [ADDR_BITS-1:0]     up_lo,
   input  logic [ADDR_BITS-1:0]     up_hi,
   output rac_pkg::rac_ctl_type     dn_ctl,
   output logic [ADDR_BITS-1:0]     dn_lo,
   output logic [ADDR_BITS-1:0]     dn_hi
);
   import rac_pkg::*;

   // region held by this cell: live means valid, usable and readable
   logic                 live_ff, live_in;
   logic                 wr_ff, wr_in;
   logic [ADDR_BITS-1:0] base_ff, base_in;
   logic [ADDR_BITS-1:0] end_ff, end_in;

   // transaction handed to the next cell
   rac_ctl_type          ctl_ff, ctl_in;
   logic [ADDR_BITS-1:0] lo_ff;
   logic [ADDR_BITS-1:0] hi_ff;

   logic                 hit_now;

   // access fully inside this region with the needed permissions
   assign hit_now = up_ctl.ok && live_ff && (wr_ff || !up_ctl.want_write) &&
                    (up_lo >= base_ff) && (up_hi <= end_ff);

   // act on the passing transaction
   always_comb begin
      live_in = live_ff;
      wr_in   = wr_ff;
      base_in = base_ff;
      end_in  = end_ff;
      ctl_in  = up_ctl;
      if (up_ctl.valid) begin
         unique case (up_ctl.cmd)
            CMD_CHECK: begin
               ctl_in.hit = up_ctl.hit | hit_now;
            end
            CMD_WRITE: begin
               if (int'(up_ctl.slot) == INDEX) begin
                  live_in = up_ctl.ok & up_ctl.rd;
                  wr_in   = up_ctl.wr;
                  base_in = up_lo;
                  end_in  = up_hi;
               end
            end
            CMD_CLEAR: begin
               live_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
         ctl_ff  <= '0;
      end else begin
         live_ff <= live_in;
         ctl_ff  <= ctl_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      wr_ff   <= wr_in;
      base_ff <= base_in;
      end_ff  <= end_in;
      lo_ff   <= up_lo;
      hi_ff   <= up_hi;
   end

   assign dn_ctl = ctl_ff;
   assign dn_lo  = lo_ff;
   assign dn_hi  = hi_ff;

endmodule

/* hdl/region_access_checker.sv */
// region access checker top level: entry stage and a chain of region cells
// depends on rac_pkg and rac_cell
//
//   channel   ports                    transfer
//   request   start, busy, req_*       start high and busy low at a clock edge
//   response  rsp_strobe, rsp_*        one cycle per transaction, no back-pressure
//
// every transaction gives one response after passing the entry stage and every cell
// a transaction is taken every cycle busy is low; the chain moves one step a cycle
// each cell holds one slot, so writes and clears act in order with checks
// reset clears all slots and holds busy high; busy falls in the cycle after release
// the response side cannot stall, so the chain never stops
`timescale 1ns / 1ps

module region_access_checker #(
   parameter int REGION_SLOTS = 16,
   parameter int ADDR_BITS    = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_command,
   input  logic [rac_pkg::SLOT_BITS-1:0]      req_slot,
   input  logic [rac_pkg::FIELD_BITS-1:0]     req_region_base,
   input  logic [rac_pkg::FIELD_BITS-1:0]     req_region_size,
   input  logic                               req_allow_read,
   input  logic                               req_allow_write,
   input  logic [rac_pkg::FIELD_BITS-1:0]     req_access_addr,
   input  logic [rac_pkg::FIELD_BITS-1:0]     req_access_len,
   input  logic                               req_want_write,
   output logic                               rsp_strobe,
   output logic                               rsp_granted
);
   import rac_pkg::*;

   logic                 busy_ff;
   logic                 accept;
   rac_cmd_type          cmd;

   // request fields at address width
   logic [ADDR_BITS-1:0] addr_w, len_w, base_w, size_w;
   logic [ADDR_BITS:0]   acc_sum, reg_sum;

   // entry stage
   rac_ctl_type          entry_ctl_ff, entry_ctl_in;
   logic [ADDR_BITS-1:0] entry_lo_ff, entry_lo_in;
   logic [ADDR_BITS-1:0] entry_hi_ff, entry_hi_in;

   // chain links, index 0 is the entry stage
   rac_ctl_type          chain_ctl [REGION_SLOTS+1];
   logic [ADDR_BITS-1:0] chain_lo  [REGION_SLOTS+1];
   logic [ADDR_BITS-1:0] chain_hi  [REGION_SLOTS+1];

   assign accept = start & ~busy_ff;
   assign busy   = busy_ff;
   assign cmd    = rac_cmd_type'(req_command);

   // range ends and overflow checks
   assign addr_w  = ADDR_BITS'(req_access_addr);
   assign len_w   = ADDR_BITS'(req_access_len);
   assign base_w  = ADDR_BITS'(req_region_base);
   assign size_w  = ADDR_BITS'(req_region_size);
   assign acc_sum = {1'b0, addr_w} + {1'b0, len_w};
   assign reg_sum = {1'b0, base_w} + {1'b0, size_w};

   // build the transaction that enters the chain
   always_comb begin
      entry_ctl_in            = '0;
      entry_ctl_in.valid      = accept;
      entry_ctl_in.cmd        = cmd;
      entry_ctl_in.slot       = req_slot;
      entry_ctl_in.rd         = req_allow_read;
      entry_ctl_in.wr         = req_allow_write;
      entry_ctl_in.want_write = req_want_write;
      entry_ctl_in.hit        = 1'b0;
      if (cmd == CMD_CHECK) begin
         entry_ctl_in.ok = (len_w != '0) && !acc_sum[ADDR_BITS];
         entry_lo_in     = addr_w;
         entry_hi_in     = acc_sum[ADDR_BITS-1:0];
      end else begin
         entry_ctl_in.ok = (size_w != '0) && !reg_sum[ADDR_BITS];
         entry_lo_in     = base_w;
         entry_hi_in     = reg_sum[ADDR_BITS-1:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         entry_ctl_ff <= '0;
      end else begin
         busy_ff      <= 1'b0;
         entry_ctl_ff <= entry_ctl_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      entry_lo_ff <= entry_lo_in;
      entry_hi_ff <= entry_hi_in;
   end

   assign chain_ctl[0] = entry_ctl_ff;
   assign chain_lo[0]  = entry_lo_ff;
   assign chain_hi[0]  = entry_hi_ff;

   // one cell per region slot
   for (genvar g = 0; g < REGION_SLOTS; g++) begin : g_cell
      rac_cell #(
         .INDEX     (g),
         .ADDR_BITS (ADDR_BITS)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .up_ctl (chain_ctl[g]),
         .up_lo  (chain_lo[g]),
         .up_hi  (chain_hi[g]),
         .dn_ctl (chain_ctl[g+1]),
         .dn_lo  (chain_lo[g+1]),
         .dn_hi  (chain_hi[g+1])
      );
   end

   // response from the end of the chain
   assign rsp_strobe  = chain_ctl[REGION_SLOTS].valid;
   assign rsp_granted = chain_ctl[REGION_SLOTS].valid && chain_ctl[REGION_SLOTS].hit &&
                        (chain_ctl[REGION_SLOTS].cmd == CMD_CHECK);

`ifndef SYNTH
   // every transaction taken gives a response after the full chain
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(REGION_SLOTS+1) rsp_strobe)
      else $error("response missing after transaction");

   // no response without a transaction taken
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, REGION_SLOTS+1))
      else $error("response without transaction");

   // a grant only answers a check command
   a_grant_check : assert property (@(posedge clock) disable iff (reset)
      rsp_granted |-> $past(req_command == CMD_CHECK, REGION_SLOTS+1))
      else $error("grant for a command other than check");
`endif

endmodule
